/* src/twspi_pkg.sv */
// ----------------------------------------------------------------------------
// twspi_pkg
// Shared types and constants for the three-wire serial transaction master.
// ----------------------------------------------------------------------------
`default_nettype none

package twspi_pkg;

   // Fixed field widths of the request and response beats.
   localparam int HdrBitsW    = 9;
   localparam int WrValW      = 16;
   localparam int RdValW      = 16;
   localparam int ReadFlagBit = 7;

   // Packed beat widths, padded to whole bytes.
   localparam int ReqDataW = 32;
   localparam int RspDataW = 24;

   // Request kinds carried on req_tuser.
   localparam logic ActStart = 1'b0;
   localparam logic ActTick  = 1'b1;

   // Transaction sequencer phases, one-hot.
   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_PRE  = 6'b000010,
      PH_HDR  = 6'b000100,
      PH_TURN = 6'b001000,
      PH_DATA = 6'b010000,
      PH_POST = 6'b100000
   } phase_type;

   // Pin levels and status reported for one tick.
   typedef struct packed {
      logic [RdValW-1:0] read_value;
      logic              done_res;
      logic              busy_res;
      logic              enable_n;
      logic              data_drive;
      logic              data_level;
      logic              clock_level;
   } rsp_type;

endpackage

`default_nettype wire

/* src/twspi_seq.sv */
// ----------------------------------------------------------------------------
// twspi_seq
// Transaction sequencer: phase, clock count, shift registers and pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

module twspi_seq
   import twspi_pkg::*;
#(
   parameter int HEADER_LEN  = 9,
   parameter int DATA_LEN    = 16,
   parameter int PRE_CLOCKS  = 2,
   parameter int POST_CLOCKS = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire logic                action,
   input  wire logic [HdrBitsW-1:0] header_bits,
   input  wire logic [WrValW-1:0]   write_value,
   input  wire logic                pin_sample,
   output rsp_type                  rsp
);

   localparam int ShiftW  = HEADER_LEN + DATA_LEN;
   localparam int MaxLen0 = (HEADER_LEN > DATA_LEN) ? HEADER_LEN : DATA_LEN;
   localparam int MaxLen1 = (PRE_CLOCKS > MaxLen0) ? PRE_CLOCKS : MaxLen0;
   localparam int MaxLen  = (POST_CLOCKS > MaxLen1) ? POST_CLOCKS : MaxLen1;
   localparam int CntW    = $clog2(MaxLen);

   localparam logic [CntW-1:0] PreLast  = CntW'((PRE_CLOCKS > 0) ? PRE_CLOCKS - 1 : 0);
   localparam logic [CntW-1:0] HdrLast  = CntW'(HEADER_LEN - 1);
   localparam logic [CntW-1:0] DataLast = CntW'(DATA_LEN - 1);
   localparam logic [CntW-1:0] PostLast = CntW'((POST_CLOCKS > 0) ? POST_CLOCKS - 1 : 0);

   phase_type          phase_ff, phase_in, rep_phase;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               half_ff, half_in;
   logic [ShiftW-1:0]  shift_ff, shift_in;
   logic [RdValW-1:0]  rx_ff, rx_in;
   logic               read_ff, read_in, rep_read;
   logic               held_ff, held_in;
   logic               clk_lvl, done, last;
   phase_type          after_phase;

   // End of the current phase and the phase that follows it.
   always_comb begin
      last        = 1'b0;
      after_phase = PH_IDLE;
      case (phase_ff)
         PH_PRE: begin
            last        = (cnt_ff == PreLast);
            after_phase = PH_HDR;
         end
         PH_HDR: begin
            last        = (cnt_ff == HdrLast);
            after_phase = read_ff ? PH_TURN : PH_DATA;
         end
         PH_TURN: begin
            last        = 1'b1;
            after_phase = PH_DATA;
         end
         PH_DATA: begin
            last        = (cnt_ff == DataLast);
            after_phase = (POST_CLOCKS > 0) ? PH_POST : PH_IDLE;
         end
         PH_POST: begin
            last        = (cnt_ff == PostLast);
            after_phase = PH_IDLE;
         end
         default: begin
            last        = 1'b0;
            after_phase = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      half_in   = half_ff;
      shift_in  = shift_ff;
      rx_in     = rx_ff;
      read_in   = read_ff;
      held_in   = held_ff;
      clk_lvl   = half_ff;
      done      = 1'b0;
      rep_phase = phase_ff;
      rep_read  = read_ff;

      if (action == ActStart || phase_ff == PH_IDLE) begin
         if (action == ActStart && phase_ff == PH_IDLE) begin
            read_in  = header_bits[ReadFlagBit];
            shift_in = {HEADER_LEN'(header_bits), DATA_LEN'(write_value)};
            cnt_in   = '0;
            half_in  = 1'b0;
            phase_in = (PRE_CLOCKS > 0) ? PH_PRE : PH_HDR;
         end
         rep_phase = phase_in;
         rep_read  = read_in;
         clk_lvl   = half_in;
      end else if (!half_ff) begin
         // Rising half: the next header or data bit goes onto the pin latch.
         if (phase_ff == PH_HDR || phase_ff == PH_DATA) begin
            held_in  = shift_ff[ShiftW-1];
            shift_in = shift_ff << 1;
         end
         clk_lvl = 1'b1;
         half_in = 1'b1;
      end else begin
         // Falling half: sample read data and count the clock.
         clk_lvl = 1'b0;
         half_in = 1'b0;
         if (phase_ff == PH_DATA && read_ff) begin
            rx_in = {rx_ff[RdValW-2:0], pin_sample};
         end
         if (last) begin
            cnt_in   = '0;
            phase_in = after_phase;
            done     = (after_phase == PH_IDLE);
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         half_ff  <= 1'b0;
         shift_ff <= '0;
         rx_ff    <= '0;
         read_ff  <= 1'b0;
         held_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         half_ff  <= half_in;
         shift_ff <= shift_in;
         rx_ff    <= rx_in;
         read_ff  <= read_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      rsp.clock_level = clk_lvl;
      rsp.data_level  = held_in;
      rsp.data_drive  = !(rep_phase == PH_TURN || (rep_phase == PH_DATA && rep_read));
      rsp.enable_n    = !(rep_phase == PH_HDR || rep_phase == PH_TURN ||
                          rep_phase == PH_DATA);
      rsp.busy_res    = (rep_phase != PH_IDLE);
      rsp.done_res    = done;
      rsp.read_value  = rx_in;
   end

endmodule

`default_nettype wire

/* src/three_wire_spi_transaction_master_core.sv */
// ----------------------------------------------------------------------------
// three_wire_spi_transaction_master_core
// Three-wire serial transaction master driven one half clock per request beat.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Beat contents
//  --------+-----------+--------------------------------------------------------
//  req_    | in        | tuser: action; tdata: header, write value, pin sample
//  rsp_    | out       | tdata: pin levels, busy, done, received read value
//
// Every request beat is handled in the cycle it is accepted and yields one
// response beat, so the block sustains one beat per clock cycle while req_tready stays high.
// The sequencer registers update at the accepting edge; the response is
// captured into a two-entry output buffer (output register plus skid stage).
// req_tready drops only when both buffer entries hold beats not yet taken.
// reset is synchronous and active high; it returns the sequencer to idle
// with the clock low, the data latch at zero and an empty output buffer.
//
`default_nettype none

module three_wire_spi_transaction_master_core
   import twspi_pkg::*;
#(
   parameter int HEADER_LEN  = 9,
   parameter int DATA_LEN    = 16,
   parameter int PRE_CLOCKS  = 2,
   parameter int POST_CLOCKS = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_tvalid,
   output      logic                req_tready,
   // [8:0] header_bits, [24:9] write_value, [25] pin_sample, [31:26] zero
   input  wire logic [ReqDataW-1:0] req_tdata,
   // [0] action: 0 = start a transaction, 1 = one half-clock tick
   input  wire logic                req_tuser,

   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   // [0] clock_level, [1] data_level, [2] data_drive, [3] enable_n,
   // [4] busy_res, [5] done_res, [21:6] read_value, [23:22] zero
   output      logic [RspDataW-1:0] rsp_tdata
);

   localparam int RspW = $bits(rsp_type);

   logic    req_acc;
   logic    rsp_pop;
   rsp_type step_rsp;

   rsp_type out_ff, out_in;
   logic    out_vld_ff, out_vld_in;
   rsp_type skid_ff, skid_in;
   logic    skid_vld_ff, skid_vld_in;

   // The sequencer advances only on an accepted beat.
   twspi_seq #(
      .HEADER_LEN  (HEADER_LEN),
      .DATA_LEN    (DATA_LEN),
      .PRE_CLOCKS  (PRE_CLOCKS),
      .POST_CLOCKS (POST_CLOCKS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_acc),
      .action      (req_tuser),
      .header_bits (req_tdata[HdrBitsW-1:0]),
      .write_value (req_tdata[HdrBitsW +: WrValW]),
      .pin_sample  (req_tdata[HdrBitsW + WrValW]),
      .rsp         (step_rsp)
   );

   assign req_tready = !skid_vld_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_pop    = out_vld_ff && rsp_tready;

   // Output buffer: a new beat goes to the output register when it is free
   // or draining, otherwise it parks in the skid stage.
   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (rsp_pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (req_acc) begin
         if (!out_vld_ff || rsp_pop) begin
            out_in     = step_rsp;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = step_rsp;
            skid_vld_in = 1'b1;
         end
      end else if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RspDataW - RspW){1'b0}}, out_ff};

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-wire serial transaction master core.
// Request beats (starts and half-clock ticks) are queued up front and sent in
// random bursts. A line model inside the bench predicts the pin levels of
// every accepted beat, and each response beat is checked field by field,
// in order, while the response side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import twspi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The core is built with its default sizes; the line model uses the same.
   localparam int HEADER_LEN  = 9;
   localparam int DATA_LEN    = 16;
   localparam int PRE_CLOCKS  = 2;
   localparam int POST_CLOCKS = 1;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_BEATS = 800;
   localparam int HOLD_AT      = 300;   // beats in before the long hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 4000;  // cycles with no beat on either side
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX   = 40;

   typedef struct packed {
      logic                act;
      logic [HdrBitsW-1:0] hdr;
      logic [WrValW-1:0]   wval;
      logic                pin;
   } req_beat_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                req_tuser  = ActTick;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   three_wire_spi_transaction_master_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Line model: the serial sequencer as seen from the pins.
   // -------------------------------------------------------------------------
   phase_type                    ln_phase = PH_IDLE;
   int unsigned                  ln_count = 0;
   logic                         ln_half  = 1'b0;
   logic [HEADER_LEN+DATA_LEN-1:0] ln_out = '0;
   logic [RdValW-1:0]            ln_in    = '0;
   logic                         ln_read  = 1'b0;
   logic                         ln_held  = 1'b0;

   function automatic int unsigned clocks_in(phase_type p);
      case (p)
         PH_PRE:  return PRE_CLOCKS;
         PH_HDR:  return HEADER_LEN;
         PH_TURN: return ln_read ? 1 : 0;
         PH_DATA: return DATA_LEN;
         PH_POST: return POST_CLOCKS;
         default: return 0;
      endcase
   endfunction

   function automatic phase_type succ(phase_type p);
      case (p)
         PH_PRE:  return PH_HDR;
         PH_HDR:  return PH_TURN;
         PH_TURN: return PH_DATA;
         PH_DATA: return PH_POST;
         default: return PH_IDLE;
      endcase
   endfunction

   // Skips phases that have no clocks in them, e.g. the turnaround on a write.
   function automatic phase_type settle(phase_type p);
      phase_type q;
      q = p;
      while (q != PH_IDLE && clocks_in(q) == 0)
         q = succ(q);
      return q;
   endfunction

   function automatic logic enable_of(phase_type p);
      return (p == PH_HDR || p == PH_TURN || p == PH_DATA) ? 1'b0 : 1'b1;
   endfunction

   function automatic logic drive_of(phase_type p);
      if (p == PH_TURN)
         return 1'b0;
      if (p == PH_DATA && ln_read)
         return 1'b0;
      return 1'b1;
   endfunction

   task automatic step_line(input req_beat_type b, output rsp_type r);
      phase_type p;
      logic      clk_lv;
      logic      done;
      p      = ln_phase;
      done   = 1'b0;
      r      = '0;
      if (b.act == ActStart || p == PH_IDLE) begin
         // A start while busy and a tick while idle leave everything alone.
         if (b.act == ActStart && p == PH_IDLE) begin
            ln_read  = b.hdr[ReadFlagBit];
            ln_out   = {b.hdr[HEADER_LEN-1:0], b.wval[DATA_LEN-1:0]};
            ln_count = 0;
            ln_half  = 1'b0;
            ln_phase = settle(PH_PRE);
         end
         clk_lv       = ln_half;
         r.enable_n   = enable_of(ln_phase);
         r.data_drive = drive_of(ln_phase);
         r.busy_res   = (ln_phase != PH_IDLE);
      end else begin
         r.enable_n   = enable_of(p);
         r.data_drive = drive_of(p);
         r.busy_res   = 1'b1;
         if (!ln_half) begin
            // Rising tick: the next bit goes onto the latch with the clock.
            if (p == PH_HDR)
               ln_held = ln_out[DATA_LEN + HEADER_LEN - 1 - ln_count];
            else if (p == PH_DATA)
               ln_held = ln_out[DATA_LEN - 1 - ln_count];
            clk_lv  = 1'b1;
            ln_half = 1'b1;
         end else begin
            clk_lv  = 1'b0;
            ln_half = 1'b0;
            if (p == PH_DATA && ln_read)
               ln_in = {ln_in[RdValW-2:0], b.pin};
            ln_count++;
            if (ln_count >= clocks_in(p)) begin
               ln_count = 0;
               ln_phase = settle(succ(p));
               if (ln_phase == PH_IDLE)
                  done = 1'b1;
            end
         end
      end
      r.clock_level = clk_lv;
      r.data_level  = ln_held;
      r.done_res    = done;
      r.read_value  = ln_in;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus store. gen_left tracks how many ticks the transaction that the
   // generator has started still needs, so random content stays well formed.
   // -------------------------------------------------------------------------
   req_beat_type beats_to_send[$];
   int unsigned  gen_left   = 0;
   int unsigned  gen_useful = 0;
   int unsigned  pin_mode   = 2;

   task automatic queue_beat(input logic act, input logic [HdrBitsW-1:0] hdr,
                             input logic [WrValW-1:0] wv, input logic pin);
      req_beat_type b;
      b.act  = act;
      b.hdr  = hdr;
      b.wval = wv;
      b.pin  = pin;
      beats_to_send.push_back(b);
      if (act == ActStart && gen_left == 0) begin
         gen_left = 2 * (PRE_CLOCKS + HEADER_LEN + (hdr[ReadFlagBit] ? 1 : 0)
                         + DATA_LEN + POST_CLOCKS);
         gen_useful++;
      end else if (act == ActTick && gen_left > 0) begin
         gen_left--;
         gen_useful++;
      end
   endtask

   function automatic logic pick_pin();
      case (pin_mode)
         0:       return 1'b0;
         1:       return 1'b1;
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic fill_stimulus();
      logic [HdrBitsW-1:0] hdr;
      logic [WrValW-1:0]   wv;
      // Directed opening: tick while idle, a write start with every address
      // bit set and all-ones data, a start while busy, then the first ticks.
      queue_beat(ActTick, 9'h1FF, 16'hFFFF, 1'b1);
      queue_beat(ActStart, 9'h17F, 16'hFFFF, 1'b0);
      queue_beat(ActStart, 9'h1FF, 16'h0000, 1'b1);
      repeat (20)
         queue_beat(ActTick, 9'h000, 16'h0000, 1'b1);

      while (gen_useful < RANDOM_BEATS || gen_left > 0) begin
         if (gen_left > 0) begin
            if ($urandom_range(0, 19) == 0)
               queue_beat(ActStart, HdrBitsW'($urandom), WrValW'($urandom),
                          1'($urandom_range(0, 1)));
            else
               queue_beat(ActTick, HdrBitsW'($urandom), WrValW'($urandom), pick_pin());
         end else if ($urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 5))
               0:       hdr = '0;
               1:       hdr = '1;
               default: hdr = HdrBitsW'($urandom);
            endcase
            case ($urandom_range(0, 5))
               0:       wv = '0;
               1:       wv = '1;
               default: wv = WrValW'($urandom);
            endcase
            pin_mode = $urandom_range(0, 3);
            queue_beat(ActStart, hdr, wv, 1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 4))
               queue_beat(1'($urandom_range(0, 1)), HdrBitsW'($urandom),
                          WrValW'($urandom), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps.
   // -------------------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin : req_driver
      req_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (beats_to_send.size() > 0) begin
            b = beats_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {{(ReqDataW - HdrBitsW - WrValW - 1){1'b0}}, b.pin, b.wval, b.hdr};
            req_tuser  <= b.act;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response side: stall modes that change at random intervals, and one
   // long hold-off so that the output buffer fills and req_tready drops.
   // -------------------------------------------------------------------------
   int unsigned beats_in   = 0;
   int unsigned hold_left  = 0;
   logic        hold_done  = 1'b0;
   int unsigned stall_mode = 0;
   int unsigned mode_left  = 0;
   logic [7:0]  stall_cnt  = '0;

   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 1'b1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!hold_done && beats_in >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 128);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (stall_cnt[3:2] != 2'b11);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: predicts on every accepted request beat and checks every
   // accepted response beat against the oldest prediction.
   // -------------------------------------------------------------------------
   rsp_type     pin_levels_due[$];
   int unsigned errors    = 0;
   int unsigned beats_out = 0;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (errors < REPORT_MAX)
         $display("MISMATCH response beat %0d %s: got 0x%0h, expected 0x%0h",
                  beats_out, what, got, want);
      errors++;
   endtask

   task automatic check_field(input string what, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : monitor
      rsp_type      got;
      rsp_type      want;
      req_beat_type b;
      if (!reset) begin
         // Check first: a response never belongs to a beat accepted this edge.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_type)-1:0];
            if (pin_levels_due.size() == 0) begin
               report_mismatch("with nothing expected", 32'(got), 0);
            end else begin
               want = pin_levels_due.pop_front();
               check_field("clock_level", got.clock_level, want.clock_level);
               check_field("data_level", got.data_level, want.data_level);
               check_field("data_drive", got.data_drive, want.data_drive);
               check_field("enable_n", got.enable_n, want.enable_n);
               check_field("busy_res", got.busy_res, want.busy_res);
               check_field("done_res", got.done_res, want.done_res);
               check_field("read_value", got.read_value, want.read_value);
            end
            beats_out++;
         end
         if (req_tvalid && req_tready) begin
            b.act  = req_tuser;
            b.hdr  = req_tdata[HdrBitsW-1:0];
            b.wval = req_tdata[HdrBitsW +: WrValW];
            b.pin  = req_tdata[HdrBitsW + WrValW];
            step_line(b, want);
            pin_levels_due.push_back(want);
            beats_in <= beats_in + 1;
         end
      end
   end

   // Watchdog: ends the run when neither channel moves a beat for too long.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("three_wire_spi_transaction_master_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      fill_stimulus();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      while (beats_to_send.size() > 0 || req_tvalid)
         @(posedge clock);
      while (pin_levels_due.size() > 0)
         @(posedge clock);
      // Let any stray response beat show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pin_levels_due.size() == 0)
         $display("three_wire_spi_transaction_master_core verification clean");
      else
         $display("three_wire_spi_transaction_master_core verification failed");
      $finish;
   end

endmodule

`default_nettype wire
